// ===== src/wmcjp_pkg.sv =====
// Shared types and constants for the windowed minimum-cost jump path block.
package wmcjp_pkg;

    localparam int HEIGHT_W = 16;
    localparam int COST_W   = 32;
    localparam int JUMP_W   = 8;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // One input transaction: a stone height and the end-of-sequence flag.
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                last;
    } in_t;

    // One result transaction: the best cost and the end-of-sequence flag.
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              last_res;
    } out_t;

    // A stored window entry: a previous stone's height and best cost.
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COST_W-1:0]   cost;
    } entry_t;

    // The query that travels down the chain of cells.
    typedef struct packed {
        logic                valid;
        logic [HEIGHT_W-1:0] height;
        logic [COST_W-1:0]   best;
    } token_t;

    // Top-level control states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

endpackage

// ===== src/wmcjp_cell.sv =====
// One window cell: holds a previous stone and folds it into a passing query.
module wmcjp_cell import wmcjp_pkg::*; #(
    parameter int CNT_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  entry_t           entry_in,
    output entry_t           entry_out,
    input  token_t           tok_in,
    input  logic [CNT_W-1:0] rem_in,
    output token_t           tok_out,
    output logic [CNT_W-1:0] rem_out
);

    entry_t               entry_reg;
    token_t               tok_reg;
    token_t               tok_next;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [HEIGHT_W-1:0]  diff;
    logic [COST_W:0]      cand;
    logic [COST_W-1:0]    cand_sat;
    logic                 in_span;

    // Window entry moves one cell further back whenever a stone is committed.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

    // Candidate cost of jumping from this cell's stone to the queried stone.
    always_comb begin
        in_span  = (rem_in != '0);
        diff     = (tok_in.height >= entry_reg.height) ? (tok_in.height - entry_reg.height)
                                                       : (entry_reg.height - tok_in.height);
        cand     = {1'b0, entry_reg.cost} + {{(COST_W + 1 - HEIGHT_W){1'b0}}, diff};
        cand_sat = cand[COST_W] ? COST_MAX : cand[COST_W-1:0];

        tok_next = tok_in;
        rem_next = '0;
        if (in_span) begin
            rem_next = rem_in - 1'b1;
            if (cand_sat < tok_in.best) begin
                tok_next.best = cand_sat;
            end
        end
    end

    // Query stage register hands the running minimum to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.height <= tok_next.height;
        tok_reg.best   <= tok_next.best;
        rem_reg        <= rem_next;
    end

    assign tok_out = tok_reg;
    assign rem_out = rem_reg;

endmodule

// ===== src/windowed_min_cost_jump_path_top.sv =====
// Top level of the windowed minimum-cost jump path block.
// Each input transaction carries one stone height; the block returns one result
// transaction with the least total cost of reaching that stone from the first stone
// of the sequence, where one jump spans 1 to max_jump stones and costs the absolute
// height difference (saturating at 2^32-1). The window is a chain of MAX_WINDOW
// cells, newest stone in the first cell. A query enters the first cell and moves one
// cell per clock, folding in each cell within the jump span. When the query leaves
// the chain, the control moves to the hold state, and the result is loaded into the
// output register on commit. Only one stone is in flight at a time: no new stone
// is accepted until the last one is committed, and a result still waiting in the
// output register holds the block in the hold state and stalls the input.
// A stone flagged last empties the window.
// max_jump values of 0 act as 1, values above MAX_WINDOW act as MAX_WINDOW.
module windowed_min_cost_jump_path_top import wmcjp_pkg::*; #(
    parameter int MAX_WINDOW = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [JUMP_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [JUMP_W-1:0]   max_jump_reg;
    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    filled_reg;
    logic [CNT_W-1:0]    jump_lim;
    logic [CNT_W-1:0]    span;
    logic [HEIGHT_W-1:0] height_reg;
    logic                last_reg;
    logic [COST_W-1:0]   best_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;
    logic                accept;
    logic                commit;
    token_t              launch_tok;

    token_t              tok_chain  [MAX_WINDOW+1];
    logic [CNT_W-1:0]    rem_chain  [MAX_WINDOW+1];
    entry_t              entry_chain[MAX_WINDOW+1];

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_jump_reg <= JUMP_W'(1);
        end else if (cfg_wr_en) begin
            max_jump_reg <= cfg_wr_data;
        end
    end

    // Effective jump span: clamp the register, then limit to the filled entries.
    always_comb begin
        if (max_jump_reg == '0) begin
            jump_lim = CNT_W'(1);
        end else if (32'(max_jump_reg) > 32'(MAX_WINDOW)) begin
            jump_lim = CNT_W'(MAX_WINDOW);
        end else begin
            jump_lim = CNT_W'(max_jump_reg);
        end
        span = (jump_lim < filled_reg) ? jump_lim : filled_reg;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    // Query launched into the first cell when a stone is accepted.
    always_comb begin
        launch_tok.valid  = accept;
        launch_tok.height = s_data.height;
        launch_tok.best   = (filled_reg == '0) ? '0 : COST_MAX;
    end

    assign tok_chain[0]   = launch_tok;
    assign rem_chain[0]   = accept ? span : '0;
    assign entry_chain[0] = '{height: height_reg, cost: best_reg};

    // The chain of window cells.
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        wmcjp_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (commit),
            .entry_in  (entry_chain[i]),
            .entry_out (entry_chain[i+1]),
            .tok_in    (tok_chain[i]),
            .rem_in    (rem_chain[i]),
            .tok_out   (tok_chain[i+1]),
            .rem_out   (rem_chain[i+1])
        );
    end

    // Control sequencing: accept, wait for the query to leave the chain, commit.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_chain[MAX_WINDOW].valid) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Current stone held for the window update and the result.
    always_ff @(posedge aclk) begin
        if (accept) begin
            height_reg <= s_data.height;
            last_reg   <= s_data.last;
        end
        if ((state_reg == ST_SCAN) && tok_chain[MAX_WINDOW].valid) begin
            best_reg <= tok_chain[MAX_WINDOW].best;
        end
    end

    // Fill count follows each committed stone; the last stone empties the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
        end else if (commit) begin
            if (last_reg) begin
                filled_reg <= '0;
            end else if (filled_reg < CNT_W'(MAX_WINDOW)) begin
                filled_reg <= filled_reg + 1'b1;
            end
        end
    end

    // Output register for the result transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (commit) begin
            m_data_reg.cost     <= best_reg;
            m_data_reg.last_res <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== test/tb_windowed_min_cost_jump_path_top.sv =====
// Self-checking testbench for the windowed minimum-cost jump path block.
module tb_windowed_min_cost_jump_path_top;
    import wmcjp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN      = 128;
    localparam int RANDOM_ITEMS = 1400;
    localparam int STALL_LIMIT  = 4000;
    localparam int PRESSURE_AT  = 40;
    localparam int PRESSURE_LEN = 700;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [JUMP_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_t               s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_t              m_data;

    // Stones waiting to be sent and costs waiting to come back.
    in_t  stone_q[$];
    out_t cost_expect_q[$];

    // Shadow copy of the jump register and the stone window.
    logic [JUMP_W-1:0]   jump_len = 8'd1;
    logic [HEIGHT_W-1:0] win_height[MAX_WIN];
    logic [COST_W-1:0]   win_cost[MAX_WIN];
    int                  fill_cnt = 0;
    int                  wr_ptr   = 0;

    int   send_gap      = 0;
    int   recv_hold     = 0;
    int   results_seen  = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    logic pressure_done = 1'b0;

    windowed_min_cost_jump_path_top #(.MAX_WINDOW(MAX_WIN)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length between transactions: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 98) return $urandom_range(5, 30);
        return $urandom_range(100, 300);
    endfunction

    // Work out the least cost of one accepted stone and update the shadow window.
    task automatic fold_stone_cost(input in_t stone);
        logic [COST_W:0]     best;
        logic [COST_W:0]     cand;
        logic [HEIGHT_W-1:0] diff;
        int                  span;
        int                  slot;
        out_t                res;
        span = (jump_len == 0) ? 1 : ((int'(jump_len) > MAX_WIN) ? MAX_WIN : int'(jump_len));
        if (span > fill_cnt) span = fill_cnt;
        if (fill_cnt == 0) begin
            best = '0;
        end else begin
            best = {1'b0, COST_MAX};
            for (int d = 1; d <= span; d++) begin
                slot = (wr_ptr + MAX_WIN - d) % MAX_WIN;
                diff = (stone.height >= win_height[slot]) ? stone.height - win_height[slot]
                                                          : win_height[slot] - stone.height;
                cand = {1'b0, win_cost[slot]} + diff;
                if (cand < best) best = cand;
            end
            if (best > {1'b0, COST_MAX}) best = {1'b0, COST_MAX};
        end
        win_height[wr_ptr] = stone.height;
        win_cost[wr_ptr]   = best[COST_W-1:0];
        wr_ptr = (wr_ptr + 1) % MAX_WIN;
        if (fill_cnt < MAX_WIN) fill_cnt++;
        // The final stone of a sequence empties the window.
        if (stone.last) begin
            fill_cnt = 0;
            wr_ptr   = 0;
        end
        res.cost     = best[COST_W-1:0];
        res.last_res = stone.last;
        cost_expect_q = {cost_expect_q, res};
    endtask

    task automatic add_stone(input logic [HEIGHT_W-1:0] height, input logic last);
        in_t stone;
        stone.height = height;
        stone.last   = last;
        stone_q = {stone_q, stone};
    endtask

    // Block until nothing is queued, offered or outstanding.
    task automatic wait_idle();
        @(negedge aclk);
        while (stone_q.size() != 0 || s_valid || cost_expect_q.size() != 0) @(negedge aclk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_jump(input logic [JUMP_W-1:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        jump_len     = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Input driver: offers queued stones with random gaps between transactions.
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap  = 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                fold_stone_cost(s_data);
                next_valid = 1'b0;
                send_gap   = gap_len();
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (stone_q.size() != 0) begin
                    next_valid = 1'b1;
                    s_data    <= stone_q.pop_front();
                end
            end
            s_valid <= next_valid;
        end
    end

    // Result monitor: checks each transaction and applies receiver back-pressure.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (cost_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result cost=%0d last_res=%0b",
                                 m_data.cost, m_data.last_res);
                end else begin
                    want = cost_expect_q.pop_front();
                    if (m_data.cost !== want.cost || m_data.last_res !== want.last_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d expected cost=%0d last_res=%0b,",
                                     results_seen, want.cost, want.last_res,
                                     " got cost=%0d last_res=%0b",
                                     m_data.cost, m_data.last_res);
                    end
                end
                // One long hold-off, taken while stones are still queued, lets the
                // block fill up and stall its input.
                if (!pressure_done && results_seen >= PRESSURE_AT && stone_q.size() > 1) begin
                    recv_hold     = PRESSURE_LEN;
                    pressure_done = 1'b1;
                end else begin
                    recv_hold = gap_len();
                end
            end else if (recv_hold == 0 && $urandom_range(0, 63) == 0) begin
                recv_hold = gap_len();
            end
            if (recv_hold > 0) begin
                m_ready <= 1'b0;
                recv_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_windowed_min_cost_jump_path_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: directed phases first, then random phases with register changes.
    initial begin
        int                  random_stones;
        int                  seq_left;
        int                  mode;
        int                  count;
        logic                brk;
        logic [JUMP_W-1:0]   jump;
        logic [HEIGHT_W-1:0] base;
        logic [HEIGHT_W-1:0] height;
        random_stones = 0;
        seq_left      = 0;
        mode          = 0;
        base          = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Single-stone sequence, then height extremes with one-stone jumps.
        write_jump(8'd1);
        add_stone(16'd0, 1'b1);
        add_stone(16'hFFFF, 1'b0);
        add_stone(16'd0, 1'b0);
        add_stone(16'hFFFF, 1'b1);

        // A zero jump length behaves as one.
        write_jump(8'd0);
        add_stone(16'd100, 1'b0);
        add_stone(16'd5, 1'b0);
        add_stone(16'hFFFF, 1'b0);
        add_stone(16'd7, 1'b1);

        // Jump length far above the window with a short history.
        write_jump(8'd255);
        add_stone(16'd0, 1'b0);
        add_stone(16'hFFFF, 1'b0);
        add_stone(16'd1, 1'b0);
        add_stone(16'hFFFE, 1'b0);
        add_stone(16'd2, 1'b1);

        // Register change in the middle of a sequence.
        write_jump(8'd2);
        add_stone(16'd10, 1'b0);
        add_stone(16'd20, 1'b0);
        add_stone(16'd15, 1'b0);
        write_jump(8'd128);
        add_stone(16'd12, 1'b0);
        add_stone(16'hFFFF, 1'b0);
        add_stone(16'd11, 1'b1);

        // Random phases; sequences run across register changes.
        while (random_stones < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       jump = 8'd0;
                1:       jump = 8'd1;
                2:       jump = 8'd128;
                3:       jump = 8'd255;
                4:       jump = 8'd129;
                5:       jump = 8'd2;
                default: jump = 8'($urandom_range(0, 255));
            endcase
            write_jump(jump);
            count = $urandom_range(10, 120);
            repeat (count) begin
                if (seq_left == 0) begin
                    seq_left = ($urandom_range(0, 7) == 0) ? $urandom_range(129, 260)
                                                            : $urandom_range(1, 24);
                    mode = $urandom_range(0, 2);
                    base = 16'($urandom);
                end
                case (mode)
                    0:       height = 16'($urandom);
                    1:       height = base + 16'($urandom_range(0, 63));
                    default: height = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                endcase
                // Now and then a sequence ends early.
                brk = ($urandom_range(0, 39) == 0);
                add_stone(height, brk || seq_left == 1);
                seq_left = brk ? 0 : seq_left - 1;
                random_stones++;
            end
        end

        // Drain, then watch a little longer for stray results.
        wait_idle();
        repeat (MAX_WIN + 10) @(posedge aclk);
        if (mismatches == 0 && cost_expect_q.size() == 0) begin
            $display("tb_windowed_min_cost_jump_path_top OK");
        end else begin
            $display("tb_windowed_min_cost_jump_path_top NOT OK");
        end
        $finish;
    end

endmodule
